[rtl/averaged_piecewise_linear_ranger_unit_defines.svh]
// Assertion macros for the averaged piecewise-linear ranger.
// Used by the top level only; relies on clk and arst_n in the including scope.
`ifndef AVERAGED_PIECEWISE_LINEAR_RANGER_UNIT_DEFINES_SVH
`define AVERAGED_PIECEWISE_LINEAR_RANGER_UNIT_DEFINES_SVH

// Same-cycle implication, quiet while reset is asserted
`define APLR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, quiet while reset is asserted
`define APLR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/aplr_pkg.sv]
// Shared types, widths and breakpoint tables of the averaged piecewise-linear ranger.
// No dependencies; imported by every module of the block.
package aplr_pkg;

	// Field and state widths
	localparam int SAMPLE_W   = 10;
	localparam int OUT_W      = 10;
	localparam int SUM_W      = 16;
	localparam int CNT_W      = 7;
	localparam int READ_W     = 10;
	localparam int MM_W       = 10;
	localparam int PROD_W     = READ_W + MM_W;
	localparam int DIVISOR_W  = READ_W;
	localparam int DIV_CNT_W  = $clog2(PROD_W);
	localparam int MEM_DEPTH  = 1;

	// Configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_SAMPLE_COUNT = '0;
	localparam logic [CNT_W-1:0] SAMPLE_COUNT_RST = 7'd1;
	localparam logic [CNT_W-1:0] MAX_RUN = 7'd64;

	// Calibration span and breakpoints (readings fall as distance rises)
	localparam int BREAKPOINTS = 9;
	localparam int BP_IDX_W    = $clog2(BREAKPOINTS);
	localparam logic [READ_W-1:0] READ_LO = 10'd183;
	localparam logic [READ_W-1:0] READ_HI = 10'd478;
	localparam logic [READ_W-1:0] BP_READ [BREAKPOINTS] = '{
		10'd478, 10'd379, 10'd310, 10'd259, 10'd222, 10'd195, 10'd192, 10'd184, 10'd183
	};
	localparam logic [MM_W-1:0] BP_MM [BREAKPOINTS] = '{
		10'd100, 10'd150, 10'd200, 10'd250, 10'd300, 10'd350, 10'd370, 10'd390, 10'd400
	};

	// Run state kept in the state memory
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] taken;
	} acc_state_t;

	// Divider request and response
	typedef struct packed {
		logic                 start;
		logic [PROD_W-1:0]    dividend;
		logic [DIVISOR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [PROD_W-1:0] quotient;
	} div_rsp_t;

	// Selected segment and its interpolation terms
	typedef struct packed {
		logic              found;
		logic              flat;
		logic [MM_W-1:0]   d0;
		logic [MM_W-1:0]   mdiff;
		logic [READ_W-1:0] rdiff;
		logic [READ_W-1:0] span;
	} seg_t;

endpackage

[rtl/aplr_state_mem.sv]
// Run state memory: one entry holding the running sum and the sample count.
// Synchronous read through a registered output; entry reads as zero until first written.
module aplr_state_mem (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic                wr_en,
	input  aplr_pkg::acc_state_t wr_data,
	output aplr_pkg::acc_state_t rd_data
);
	import aplr_pkg::*;

	acc_state_t mem_q [MEM_DEPTH];
	acc_state_t rd_data_q;
	logic       valid_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[0] <= wr_data;
		end
	end

	// Mark the entry once written; before that it reads as the reset value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr_en) begin
			valid_q <= 1'b1;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= valid_q ? mem_q[0] : '0;
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/aplr_divider.sv]
// Restoring serial divider, one quotient bit per cycle.
// Shared by the averaging and interpolation steps; uses aplr_pkg widths.
module aplr_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  aplr_pkg::div_req_t req,
	output aplr_pkg::div_rsp_t rsp
);
	import aplr_pkg::*;

	logic [PROD_W-1:0]    quo_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] divisor_q;
	logic [DIV_CNT_W-1:0] count_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIVISOR_W:0]   rem_sh;
	logic                 fits;
	logic [DIVISOR_W:0]   rem_sub;

	// Shift in the next dividend bit and try the subtraction
	always_comb begin
		rem_sh  = {rem_q, quo_q[PROD_W-1]};
		fits    = rem_sh >= {1'b0, divisor_q};
		rem_sub = rem_sh - {1'b0, divisor_q};
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q  <= 1'b1;
				count_q <= DIV_CNT_W'(PROD_W - 1);
			end else if (busy_q) begin
				count_q <= count_q - 1'b1;
				if (count_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q     <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[PROD_W-2:0], fits};
			rem_q <= fits ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

[rtl/aplr_segment.sv]
// Breakpoint segment selection for the piecewise-linear lookup.
// Uses the breakpoint tables of aplr_pkg; purely combinational.
module aplr_segment (
	input  logic [aplr_pkg::READ_W-1:0] reading,
	output aplr_pkg::seg_t              seg
);
	import aplr_pkg::*;

	logic [BP_IDX_W-1:0] sel;
	logic [BP_IDX_W-1:0] sel_nx;
	logic                hit;
	logic [READ_W-1:0]   hi;
	logic [READ_W-1:0]   lo;
	logic [MM_W-1:0]     d0;
	logic [MM_W-1:0]     d1;

	// Pick the first segment whose ends enclose the reading
	always_comb begin
		sel = '0;
		hit = 1'b0;
		for (int j = BREAKPOINTS - 2; j >= 0; j--) begin
			if (reading <= BP_READ[j] && reading >= BP_READ[j + 1]) begin
				sel = BP_IDX_W'(j);
				hit = 1'b1;
			end
		end
	end

	// Read both segment ends and form the interpolation terms
	always_comb begin
		sel_nx     = sel + 1'b1;
		hi         = BP_READ[sel];
		lo         = BP_READ[sel_nx];
		d0         = BP_MM[sel];
		d1         = BP_MM[sel_nx];
		seg.found  = hit;
		seg.flat   = hi == lo;
		seg.d0     = d0;
		seg.mdiff  = d1 - d0;
		seg.rdiff  = hi - reading;
		seg.span   = hi - lo;
	end

endmodule

[rtl/averaged_piecewise_linear_ranger_unit.sv]
// Averaged piecewise-linear ranger. Each accepted sample is added to a run
// sum held in a one-entry state memory (read, update, write back). A sample
// that does not close the run is written back before the next one is taken.
// The sample that closes the run (sample_count samples; 0 acts as 1, above 64
// acts as 64) triggers the result: the run sum is divided by the run length,
// the average is clamped to 183..478, a segment is chosen from nine
// breakpoints, and the distance is interpolated with a second division. Both
// divisions go through one 20-bit serial divider at one bit per cycle; a flat
// segment, or a reading that no segment encloses, skips the second one. A
// finished result waits in an output register while the next run proceeds;
// the block stalls at the end of a run only if that register is still full.
// Configuration: sample_count at byte address 0, written and read over the
// APB-style port. There is no clearing pass after reset.
// Depends on aplr_pkg, aplr_state_mem, aplr_divider and aplr_segment.
`include "averaged_piecewise_linear_ranger_unit_defines.svh"

module averaged_piecewise_linear_ranger_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [aplr_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [aplr_pkg::APB_DATA_W-1:0] pwdata,
	output logic [aplr_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	// sample channel
	input  logic                            sample_valid,
	output logic                            sample_ready,
	input  logic [aplr_pkg::SAMPLE_W-1:0]   sample,
	// result channel
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic [aplr_pkg::OUT_W-1:0]      avg_reading,
	output logic [aplr_pkg::MM_W-1:0]       distance_mm
);
	import aplr_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_UPDATE = 8'b0000_0010,
		ST_AVG    = 8'b0000_0100,
		ST_SEG    = 8'b0000_1000,
		ST_MUL    = 8'b0001_0000,
		ST_DIV_GO = 8'b0010_0000,
		ST_DIST   = 8'b0100_0000,
		ST_EMIT   = 8'b1000_0000
	} fsm_t;

	fsm_t                  state_q;
	logic [CNT_W-1:0]      sample_count_q;
	logic [SAMPLE_W-1:0]   sample_q;
	logic [OUT_W-1:0]      avg_s1;
	logic [READ_W-1:0]     r_s1;
	seg_t                  seg_s2;
	logic [PROD_W-1:0]     prod_s3;
	logic [MM_W-1:0]       dist_q;
	logic                  result_valid_q;
	logic [OUT_W-1:0]      avg_reading_q;
	logic [MM_W-1:0]       distance_mm_q;

	logic                  cfg_wr;
	logic [REG_IDX_W-1:0]  reg_idx;
	logic [CNT_W-1:0]      run_len;
	logic                  accept;
	logic                  mem_wr;
	acc_state_t            mem_wr_data;
	acc_state_t            mem_rd_data;
	logic [SUM_W-1:0]      upd_sum;
	logic [CNT_W-1:0]      upd_taken;
	logic                  run_done;
	div_req_t              div_req;
	div_rsp_t              div_rsp;
	seg_t                  seg;
	logic [READ_W-1:0]     r_clamped;
	logic                  out_load;

	// Configuration register
	assign cfg_wr  = psel & penable & pwrite;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign pready  = 1'b1;
	assign prdata  = (reg_idx == REG_SAMPLE_COUNT) ? APB_DATA_W'(sample_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= SAMPLE_COUNT_RST;
		end else if (cfg_wr && reg_idx == REG_SAMPLE_COUNT) begin
			sample_count_q <= pwdata[CNT_W-1:0];
		end
	end

	// Effective run length, limited to 1..MAX_RUN
	always_comb begin
		if (sample_count_q == '0) begin
			run_len = CNT_W'(1);
		end else if (sample_count_q > MAX_RUN) begin
			run_len = MAX_RUN;
		end else begin
			run_len = sample_count_q;
		end
	end

	assign sample_ready = state_q == ST_IDLE;
	assign accept       = sample_valid & sample_ready;

	// Run state read-modify-write
	aplr_state_mem u_state_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.wr_en   (mem_wr),
		.wr_data (mem_wr_data),
		.rd_data (mem_rd_data)
	);

	always_comb begin
		upd_sum     = mem_rd_data.sum + SUM_W'(sample_q);
		upd_taken   = mem_rd_data.taken + 1'b1;
		run_done    = upd_taken >= run_len;
		mem_wr      = state_q == ST_UPDATE;
		mem_wr_data = run_done ? '0 : acc_state_t'{sum: upd_sum, taken: upd_taken};
	end

	// Shared divider: run average first, then the interpolation quotient
	always_comb begin
		div_req.start = (state_q == ST_UPDATE && run_done) || state_q == ST_DIV_GO;
		if (state_q == ST_UPDATE) begin
			div_req.dividend = PROD_W'(upd_sum);
			div_req.divisor  = DIVISOR_W'(run_len);
		end else begin
			div_req.dividend = prod_s3;
			div_req.divisor  = seg_s2.span;
		end
	end

	aplr_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Clamp the average into the calibrated span for the lookup
	always_comb begin
		if (div_rsp.quotient < PROD_W'(READ_LO)) begin
			r_clamped = READ_LO;
		end else if (div_rsp.quotient > PROD_W'(READ_HI)) begin
			r_clamped = READ_HI;
		end else begin
			r_clamped = div_rsp.quotient[READ_W-1:0];
		end
	end

	aplr_segment u_segment (
		.reading (r_s1),
		.seg     (seg)
	);

	assign out_load = state_q == ST_EMIT && (!result_valid_q || result_ready);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					state_q <= run_done ? ST_AVG : ST_IDLE;
				end
				ST_AVG: begin
					if (div_rsp.done) state_q <= ST_SEG;
				end
				ST_SEG: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= (seg_s2.found && !seg_s2.flat) ? ST_DIV_GO : ST_EMIT;
				end
				ST_DIV_GO: begin
					state_q <= ST_DIST;
				end
				ST_DIST: begin
					if (div_rsp.done) state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath stages
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample;
		end
		if (state_q == ST_AVG && div_rsp.done) begin
			avg_s1 <= div_rsp.quotient[OUT_W-1:0];
			r_s1   <= r_clamped;
		end
		if (state_q == ST_SEG) begin
			seg_s2 <= seg;
		end
		if (state_q == ST_MUL) begin
			prod_s3 <= PROD_W'(seg_s2.rdiff) * PROD_W'(seg_s2.mdiff);
			if (!seg_s2.found) begin
				dist_q <= '0;
			end else if (seg_s2.flat) begin
				dist_q <= seg_s2.d0;
			end
		end
		if (state_q == ST_DIST && div_rsp.done) begin
			dist_q <= MM_W'(PROD_W'(seg_s2.d0) + div_rsp.quotient);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			avg_reading_q <= avg_s1;
			distance_mm_q <= dist_q;
		end
	end

	assign result_valid = result_valid_q;
	assign avg_reading  = avg_reading_q;
	assign distance_mm  = distance_mm_q;

	// Checks
	`APLR_ASSERT_NOW(a_accept_div_idle, accept, !div_rsp.busy, "sample accepted while divider busy")
	`APLR_ASSERT_NOW(a_taken_in_range, mem_wr, mem_wr_data.taken < MAX_RUN, "stored count out of range")
	`APLR_ASSERT_NOW(a_div_done_state, div_rsp.done, state_q == ST_AVG || state_q == ST_DIST, "divider finished outside a wait state")
	`APLR_ASSERT_NEXT(a_update_follows, accept, state_q == ST_UPDATE, "accepted sample not updated next cycle")

endmodule
